[src/assert_macros.svh]
// Assertion helpers; define ASSERT_OFF to drop them.
// Each check runs on clk and is held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

[src/whts_pkg.sv]
package whts_pkg;

	localparam int EVENT_TYPES     = 6;
	localparam int RETRY_AFTER     = 3;
	localparam int TELEMETRY_EVERY = 15;
	localparam int PERIOD_SECONDS  = 10;

	// event bit positions
	localparam int EV_RECOVER     = 0;
	localparam int EV_UPPER_OFF   = 1;
	localparam int EV_LOWER_ON    = 2;
	localparam int EV_LOWER_ALERT = 3;
	localparam int EV_FAIL        = 4;
	localparam int EV_TIMEOUT     = 5;

	localparam int TEMP_W   = 12;
	localparam int SMOOTH_W = 21;
	localparam int ALPHA_W  = 9;
	localparam int LIMIT_W  = 8;
	localparam int MINUTE_W = 16;
	localparam int CFG_W    = 16;
	localparam int ON_W     = 19;
	localparam int SEC_W    = 6;                 // holds PERIOD_SECONDS and 60
	localparam int CAP_W    = ON_W + SEC_W;
	localparam int FAIL_W   = 8;
	localparam int RETRY_W  = $clog2(RETRY_AFTER + 1);
	localparam int TEL_W    = $clog2(TELEMETRY_EVERY + 1);
	localparam int PERIOD_W = 32;

	localparam logic [ON_W-1:0]   ON_MAX         = '1;
	localparam logic [FAIL_W-1:0] FAIL_MAX       = '1;
	localparam logic [TEMP_W-1:0] FAULT_SENTINEL = TEMP_W'(-16);
	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = ALPHA_W'(256);

	typedef logic [EVENT_TYPES-1:0] ev_mask_t;

	typedef enum logic [2:0] {
		CFG_ALPHA     = 3'd0,
		CFG_SANE_LOW  = 3'd1,
		CFG_SANE_HIGH = 3'd2,
		CFG_LOWER     = 3'd3,
		CFG_UPPER     = 3'd4,
		CFG_REHEAT    = 3'd5,
		CFG_MAX_ON    = 3'd6,
		CFG_DEBOUNCE  = 3'd7
	} cfg_reg_t;

endpackage

[src/water_heater_thermostat_supervisor.sv]
// Water heater thermostat supervisor.
// Input channel (in_valid/in_ready) carries one transaction per sensing period:
// read_ok, sensor_temp (signed 1/16 degC) and relay_in. Output channel
// (out_valid/out_ready) returns exactly one transaction per input: relay_out,
// smoothed_temp, sensor_ok, events_fired, telemetry_due, retry_sensor.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle, no
// read-back; write only while no transaction is in flight.
// Timing: the input register loads at acceptance; the result register loads
// from it when empty or when its result leaves; out_valid rises as it loads.
// Throughput: one transaction per cycle while out_ready stays high; the EMA
// update, thermostat, on-time cap and debounce compares all sit in the single
// combinational step between the two registers, bounded by the two EMA
// multipliers feeding the limit compare.
// Stall: while out_ready is low the result register holds; the input register
// still takes one more transaction, then in_ready drops until the result moves.
// Reset (arst_n low): all supervisor state clears, configuration returns to
// its defaults (alpha 77, window 0..1600, limits 0/255, no reheat, no cap,
// debounce 30); no clearing pass is needed.
module water_heater_thermostat_supervisor
	import whts_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// config write port
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       read_ok,
	input  logic signed [TEMP_W-1:0]   sensor_temp,
	input  logic                       relay_in,
	// output channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       relay_out,
	output logic signed [TEMP_W-1:0]   smoothed_temp,
	output logic                       sensor_ok,
	output logic [EVENT_TYPES-1:0]     events_fired,
	output logic                       telemetry_due,
	output logic                       retry_sensor
);

	`include "assert_macros.svh"

	// ---------------- configuration registers ----------------
	logic [ALPHA_W-1:0]        alpha_q;
	logic signed [TEMP_W-1:0]  sane_low_q;
	logic signed [TEMP_W-1:0]  sane_high_q;
	logic [LIMIT_W-1:0]        lower_q;
	logic [LIMIT_W-1:0]        upper_q;
	logic                      reheat_q;
	logic [MINUTE_W-1:0]       max_on_q;
	logic [CFG_W-1:0]          debounce_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ALPHA_W'(77);
			sane_low_q  <= '0;
			sane_high_q <= TEMP_W'(1600);
			lower_q     <= '0;
			upper_q     <= LIMIT_W'(255);
			reheat_q    <= 1'b0;
			max_on_q    <= '0;
			debounce_q  <= CFG_W'(30);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ALPHA:     alpha_q     <= cfg_data[ALPHA_W-1:0];
				CFG_SANE_LOW:  sane_low_q  <= cfg_data[TEMP_W-1:0];
				CFG_SANE_HIGH: sane_high_q <= cfg_data[TEMP_W-1:0];
				CFG_LOWER:     lower_q     <= cfg_data[LIMIT_W-1:0];
				CFG_UPPER:     upper_q     <= cfg_data[LIMIT_W-1:0];
				CFG_REHEAT:    reheat_q    <= cfg_data[0];
				CFG_MAX_ON:    max_on_q    <= cfg_data[MINUTE_W-1:0];
				CFG_DEBOUNCE:  debounce_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// ---------------- handshake / pipeline control ----------------
	logic                      valid_s1;
	logic                      read_ok_s1;
	logic signed [TEMP_W-1:0]  raw_s1;
	logic                      relay_s1;
	logic                      valid_s2;
	logic                      adv;

	// Stage 1 moves into the result register when that register is empty or
	// its current transaction leaves this cycle.
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			read_ok_s1 <= read_ok;
			raw_s1     <= sensor_temp;
			relay_s1   <= relay_in;
		end
	end

	// ---------------- supervisor state ----------------
	logic signed [SMOOTH_W-1:0] smooth_q;
	logic                       started_q;
	logic [FAIL_W-1:0]          fail_q;
	logic [RETRY_W-1:0]         retry_q;
	logic                       fault_q;
	logic [ON_W-1:0]            on_q;
	logic                       was_on_q;
	logic [TEL_W-1:0]           tel_q;
	logic [PERIOD_W-1:0]        period_q;
	ev_mask_t                   fired_q;
	logic [PERIOD_W-1:0]        last_fired_q [EVENT_TYPES];

	// ---------------- single step datapath ----------------
	logic                       good;
	logic [ALPHA_W-1:0]         a_eff;
	logic [ALPHA_W-1:0]         b_eff;
	logic signed [21:0]         prod_new;
	logic signed [30:0]         prod_old;
	logic [31:0]                mix_sum;
	logic signed [SMOOTH_W-1:0] smooth_n;
	logic [FAIL_W-1:0]          fail_n;
	logic [RETRY_W-1:0]         retry_inc;
	logic [RETRY_W-1:0]         retry_n;
	logic                       retry_hit;
	logic                       fault_n;
	logic [TEL_W-1:0]           tel_inc;
	logic [TEL_W-1:0]           tel_n;
	logic                       tel_hit;
	logic                       relay_th;
	logic [ON_W-1:0]            on_base;
	logic [ON_W-1:0]            on_inc;
	logic [ON_W-1:0]            on_n;
	logic [CAP_W-1:0]           on_secs;
	logic [CAP_W-1:0]           cap_secs;
	logic                       timeout;
	logic                       relay_fin;
	ev_mask_t                   ev_raise;
	ev_mask_t                   ev_fire;
	logic [SMOOTH_W:0]          rnd;
	logic [TEMP_W-1:0]          shown;

	always_comb begin
		good = read_ok_s1 && (raw_s1 >= sane_low_q) && (raw_s1 <= sane_high_q);

		// EMA in Q.8 of 1/16 degC; alpha above one is taken as one
		a_eff    = alpha_q[ALPHA_W-1] ? ALPHA_ONE : alpha_q;
		b_eff    = ALPHA_ONE - a_eff;
		prod_new = $signed({13'b0, a_eff}) * $signed({{10{raw_s1[TEMP_W-1]}}, raw_s1});
		prod_old = $signed({22'b0, b_eff})
			* $signed({{10{smooth_q[SMOOTH_W-1]}}, smooth_q});
		mix_sum  = {{2{prod_new[21]}}, prod_new, 8'b0}
			+ {prod_old[30], prod_old} + 32'd128;

		smooth_n  = smooth_q;
		fail_n    = fail_q;
		retry_n   = retry_q;
		retry_hit = 1'b0;
		fault_n   = fault_q;
		tel_n     = tel_q;
		tel_hit   = 1'b0;
		relay_th  = relay_s1;
		ev_raise  = '0;
		retry_inc = retry_q + RETRY_W'(1);
		tel_inc   = tel_q + TEL_W'(1);

		if (good) begin
			fail_n  = '0;
			retry_n = '0;
			if (fault_q) begin
				fault_n              = 1'b0;
				ev_raise[EV_RECOVER] = 1'b1;
			end
			if (!started_q)
				smooth_n = {raw_s1[TEMP_W-1], raw_s1, 8'b0};
			else
				smooth_n = mix_sum[28:8];
			// thermostat at full precision: whole degrees are 4096 LSB
			if (relay_s1 && smooth_n >= $signed({1'b0, upper_q, 12'b0})) begin
				relay_th               = 1'b0;
				ev_raise[EV_UPPER_OFF] = 1'b1;
			end else if (!relay_s1 && smooth_n <= $signed({1'b0, lower_q, 12'b0})) begin
				if (reheat_q) begin
					relay_th              = 1'b1;
					ev_raise[EV_LOWER_ON] = 1'b1;
				end else begin
					ev_raise[EV_LOWER_ALERT] = 1'b1;
				end
			end
			if (tel_inc >= TEL_W'(TELEMETRY_EVERY)) begin
				tel_n   = '0;
				tel_hit = 1'b1;
			end else begin
				tel_n = tel_inc;
			end
		end else begin
			if (fail_q != FAIL_MAX)
				fail_n = fail_q + FAIL_W'(1);
			if (retry_inc >= RETRY_W'(RETRY_AFTER)) begin
				retry_n   = '0;
				retry_hit = 1'b1;
			end else begin
				retry_n = retry_inc;
			end
			if (!fault_q && fail_n >= FAIL_W'(RETRY_AFTER)) begin
				fault_n           = 1'b1;
				ev_raise[EV_FAIL] = 1'b1;
			end
		end

		// continuous on-time cap, count restarts on a rising relay
		on_base  = was_on_q ? on_q : '0;
		on_inc   = (on_base != ON_MAX) ? on_base + ON_W'(1) : on_base;
		on_secs  = CAP_W'(on_inc) * CAP_W'(PERIOD_SECONDS);
		cap_secs = CAP_W'(max_on_q) * CAP_W'(60);
		timeout  = relay_th && (max_on_q != '0) && (on_secs >= cap_secs);
		relay_fin = relay_th && !timeout;
		on_n      = relay_fin ? on_inc : '0;
		ev_raise[EV_TIMEOUT] = timeout;

		// per-type debounce; the period gap is taken modulo 2^32
		for (int k = 0; k < EVENT_TYPES; k++) begin
			ev_fire[k] = ev_raise[k] && !(fired_q[k] &&
				((period_q - last_fired_q[k]) < PERIOD_W'(debounce_q)));
		end

		// round to nearest, ties upward
		rnd   = {smooth_n[SMOOTH_W-1], smooth_n} + (SMOOTH_W+1)'(128);
		shown = fault_n ? FAULT_SENTINEL : rnd[TEMP_W+7:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q  <= '0;
			started_q <= 1'b0;
			fail_q    <= '0;
			retry_q   <= '0;
			fault_q   <= 1'b0;
			on_q      <= '0;
			was_on_q  <= 1'b0;
			tel_q     <= '0;
			period_q  <= '0;
			fired_q   <= '0;
		end else if (adv) begin
			smooth_q  <= smooth_n;
			started_q <= started_q || good;
			fail_q    <= fail_n;
			retry_q   <= retry_n;
			fault_q   <= fault_n;
			on_q      <= on_n;
			was_on_q  <= relay_fin;
			tel_q     <= tel_n;
			period_q  <= period_q + PERIOD_W'(1);
			fired_q   <= fired_q | ev_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < EVENT_TYPES; k++) begin
				if (ev_fire[k])
					last_fired_q[k] <= period_q;
			end
		end
	end

	// ---------------- result register ----------------
	logic                  relay_s2;
	logic [TEMP_W-1:0]     temp_s2;
	logic                  ok_s2;
	ev_mask_t              events_s2;
	logic                  tel_s2;
	logic                  retry_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			relay_s2  <= relay_fin;
			temp_s2   <= shown;
			ok_s2     <= !fault_n;
			events_s2 <= ev_fire;
			tel_s2    <= tel_hit;
			retry_s2  <= retry_hit;
		end
	end

	assign out_valid     = valid_s2;
	assign relay_out     = relay_s2;
	assign smoothed_temp = temp_s2;
	assign sensor_ok     = ok_s2;
	assign events_fired  = events_s2;
	assign telemetry_due = tel_s2;
	assign retry_sensor  = retry_s2;

	// ---------------- checks ----------------
	`ASSERT_NEVER(a_retry_range, retry_q >= RETRY_W'(RETRY_AFTER), "retry phase out of range")
	`ASSERT_NEVER(a_no_overwrite, valid_s2 && !out_ready && adv, "result overwritten while stalled")
	`ASSERT_PROP(a_sentinel, (valid_s2 && !ok_s2) |-> (temp_s2 == FAULT_SENTINEL), "no sentinel")
	`ASSERT_PROP(a_timeout, (valid_s2 && events_s2[EV_TIMEOUT]) |-> !relay_s2, "timeout relay on")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import whts_pkg::*;

	// one sensing-period transaction as offered on the input channel
	typedef struct packed {
		logic              read_ok;
		logic [TEMP_W-1:0] raw;
		logic              relay;
	} sensor_reading_t;

	// one result transaction as returned on the output channel
	typedef struct packed {
		logic              relay;
		logic [TEMP_W-1:0] temp;
		logic              ok;
		ev_mask_t          events;
		logic              telem;
		logic              retry;
	} thermo_report_t;

	localparam int ON_CEIL = (1 << ON_W) - 1;   // on-period counter saturates here

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	cfg_reg_t          cfg_index = CFG_ALPHA;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              read_ok = 1'b0;
	logic [TEMP_W-1:0] sensor_temp = '0;
	logic              relay_in = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              relay_out;
	logic [TEMP_W-1:0] smoothed_temp;
	logic              sensor_ok;
	ev_mask_t          events_fired;
	logic              telemetry_due;
	logic              retry_sensor;

	water_heater_thermostat_supervisor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.read_ok       (read_ok),
		.sensor_temp   (sensor_temp),
		.relay_in      (relay_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.relay_out     (relay_out),
		.smoothed_temp (smoothed_temp),
		.sensor_ok     (sensor_ok),
		.events_fired  (events_fired),
		.telemetry_due (telemetry_due),
		.retry_sensor  (retry_sensor)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case a transaction never comes back
	initial begin
		#5_000_000;
		$display("water_heater_thermostat_supervisor: mismatch");
		$finish;
	end

	sensor_reading_t pending_readings[$];
	thermo_report_t  expected_reports[$];
	int              readings_taken = 0;
	int              mismatch_count = 0;
	int              hold_left = 0;

	// window of accepted transactions where neither side inserts bubbles
	wire steady = readings_taken >= 900 && readings_taken < 1150;

	// ------------------------------------------------------------------
	// Shadow of the supervisor: configuration copy plus state
	// ------------------------------------------------------------------
	int          alpha_cfg, sane_lo, sane_hi, lower_deg, upper_deg;
	int          reheat_cfg, max_on_min, debounce_len;
	int          ema, fails, retry_ph, on_cnt, tel_cnt;
	logic        ema_started, fault, was_on;
	logic [31:0] period_count;
	logic [31:0] last_fire [EVENT_TYPES];
	ev_mask_t    has_fired;

	function automatic void reset_shadow();
		alpha_cfg    = 77;
		sane_lo      = 0;
		sane_hi      = 1600;
		lower_deg    = 0;
		upper_deg    = 255;
		reheat_cfg   = 0;
		max_on_min   = 0;
		debounce_len = 30;
		ema          = 0;
		ema_started  = 1'b0;
		fails        = 0;
		retry_ph     = 0;
		fault        = 1'b0;
		on_cnt       = 0;
		was_on       = 1'b0;
		tel_cnt      = 0;
		period_count = '0;
		has_fired    = '0;
		foreach (last_fire[k])
			last_fire[k] = '0;
	endfunction

	// Debounced event: suppressed while the same type fired fewer than
	// debounce_len periods ago. Zero debounce never suppresses.
	function automatic ev_mask_t latch_event(input int kind);
		if (has_fired[kind] && (period_count - last_fire[kind]) < 32'(debounce_len))
			return '0;
		last_fire[kind] = period_count;
		has_fired[kind] = 1'b1;
		return ev_mask_t'(1) << kind;
	endfunction

	function automatic thermo_report_t supervise_period(input sensor_reading_t rd);
		thermo_report_t rep;
		logic           relay;
		int             raw_i, shown;
		longint         a, num;
		rep   = '0;
		relay = rd.relay;
		raw_i = $signed(rd.raw);
		if (rd.read_ok && raw_i >= sane_lo && raw_i <= sane_hi) begin
			fails    = 0;
			retry_ph = 0;
			if (fault) begin
				fault = 1'b0;
				rep.events |= latch_event(EV_RECOVER);
			end
			if (!ema_started) begin
				ema         = raw_i * 256;
				ema_started = 1'b1;
			end else begin
				// alpha above one is taken as one
				a   = (alpha_cfg > 256) ? 256 : alpha_cfg;
				num = a * raw_i * 256 + (256 - a) * ema + 128;
				ema = int'(num >>> 8);
			end
			// limits are whole degC against a Q.8 value in 1/16 degC
			if (relay && ema >= upper_deg * 4096) begin
				relay = 1'b0;
				rep.events |= latch_event(EV_UPPER_OFF);
			end else if (!relay && ema <= lower_deg * 4096) begin
				if (reheat_cfg != 0) begin
					relay = 1'b1;
					rep.events |= latch_event(EV_LOWER_ON);
				end else begin
					rep.events |= latch_event(EV_LOWER_ALERT);
				end
			end
			tel_cnt++;
			if (tel_cnt >= TELEMETRY_EVERY) begin
				tel_cnt   = 0;
				rep.telem = 1'b1;
			end
		end else begin
			if (fails < 255)
				fails++;
			// retry cadence keeps running after the fail count saturates
			retry_ph++;
			if (retry_ph >= RETRY_AFTER) begin
				retry_ph  = 0;
				rep.retry = 1'b1;
			end
			if (!fault && fails >= RETRY_AFTER) begin
				fault = 1'b1;
				rep.events |= latch_event(EV_FAIL);
			end
		end

		// continuous on-time cap, restarted on each rising edge of the relay
		if (relay) begin
			if (!was_on)
				on_cnt = 0;
			if (on_cnt < ON_CEIL)
				on_cnt++;
			if (max_on_min > 0 &&
					longint'(on_cnt) * PERIOD_SECONDS >= longint'(max_on_min) * 60) begin
				relay  = 1'b0;
				on_cnt = 0;
				rep.events |= latch_event(EV_TIMEOUT);
			end
		end else begin
			on_cnt = 0;
		end
		was_on = relay;

		shown = fault ? -16 : ((ema + 128) >>> 8);
		period_count++;

		rep.relay = relay;
		rep.temp  = shown[TEMP_W-1:0];
		rep.ok    = !fault;
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// Driver: input channel, fed from pending_readings
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		sensor_reading_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			// slot is free: either nothing offered or the offer was just taken
			if (pending_readings.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
				nxt = pending_readings.pop_front();
				in_valid    <= 1'b1;
				read_ok     <= nxt.read_ok;
				sensor_temp <= nxt.raw;
				relay_in    <= nxt.relay;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output ready: random stalls, plus two long hold-offs to back the
	// block up and make it drop in_ready
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (in_valid && in_ready && (readings_taken == 400 || readings_taken == 1300)) begin
			out_ready <= 1'b0;
			hold_left <= 60;
		end else begin
			out_ready <= steady || $urandom_range(0, 99) >= 14;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transaction against the oldest
	// prediction, then predicts for the input transaction taken this edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		thermo_report_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("result transaction with no prediction pending");
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					if (relay_out !== want.relay) begin
						$error("relay_out: expected %0d, got %0d", want.relay, relay_out);
						mismatch_count++;
					end
					if (smoothed_temp !== want.temp) begin
						$error("smoothed_temp: expected %0d, got %0d",
							$signed(want.temp), $signed(smoothed_temp));
						mismatch_count++;
					end
					if (sensor_ok !== want.ok) begin
						$error("sensor_ok: expected %0d, got %0d", want.ok, sensor_ok);
						mismatch_count++;
					end
					if (events_fired !== want.events) begin
						$error("events_fired: expected %b, got %b", want.events, events_fired);
						mismatch_count++;
					end
					if (telemetry_due !== want.telem) begin
						$error("telemetry_due: expected %0d, got %0d", want.telem, telemetry_due);
						mismatch_count++;
					end
					if (retry_sensor !== want.retry) begin
						$error("retry_sensor: expected %0d, got %0d", want.retry, retry_sensor);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_reports.push_back(supervise_period({read_ok, sensor_temp, relay_in}));
				readings_taken <= readings_taken + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_reading(input logic ok, input int raw, input logic relay);
		pending_readings.push_back({ok, 12'(raw), relay});
	endtask

	// everything sent, everything returned, then let the pipe settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_readings.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		logic [CFG_W-1:0] word;
		word = CFG_W'(val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		case (idx)
			CFG_ALPHA:     alpha_cfg    = word[ALPHA_W-1:0];
			CFG_SANE_LOW:  sane_lo      = $signed(word[TEMP_W-1:0]);
			CFG_SANE_HIGH: sane_hi      = $signed(word[TEMP_W-1:0]);
			CFG_LOWER:     lower_deg    = word[LIMIT_W-1:0];
			CFG_UPPER:     upper_deg    = word[LIMIT_W-1:0];
			CFG_REHEAT:    reheat_cfg   = word[0];
			CFG_MAX_ON:    max_on_min   = word[MINUTE_W-1:0];
			CFG_DEBOUNCE:  debounce_len = word[MINUTE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int alpha, input int lo, input int hi,
			input int lower, input int upper, input int reheat,
			input int max_on, input int debounce);
		write_reg(CFG_ALPHA, alpha);
		write_reg(CFG_SANE_LOW, lo);
		write_reg(CFG_SANE_HIGH, hi);
		write_reg(CFG_LOWER, lower);
		write_reg(CFG_UPPER, upper);
		write_reg(CFG_REHEAT, reheat);
		write_reg(CFG_MAX_ON, max_on);
		write_reg(CFG_DEBOUNCE, debounce);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Tank model: temperature drifts up while heating, down otherwise,
	// around the band between the limits. Mixed in: short failure bursts
	// (dropped conversions or readings outside the sane window) and some
	// fully random noise transactions.
	task automatic queue_walk(input int count);
		int              temp_now, burst, pick, lo_b, hi_b;
		logic            heating;
		sensor_reading_t rd;
		lo_b = (sane_lo > -880) ? sane_lo : -880;
		hi_b = (sane_hi < 2000) ? sane_hi : 2000;
		if (lo_b > hi_b) begin
			lo_b = -880;
			hi_b = 2000;
		end
		temp_now = (lower_deg + upper_deg) * 8;
		heating  = $urandom_range(0, 1);
		burst    = 0;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 8)
				heating = !heating;
			temp_now += heating ? int'($urandom_range(0, 40)) - 8 : 8 - int'($urandom_range(0, 40));
			if (temp_now < lo_b) temp_now = lo_b;
			if (temp_now > hi_b) temp_now = hi_b;
			rd = {1'b1, 12'(temp_now), heating};
			if (burst > 0) begin
				burst--;
				case ($urandom_range(0, 2))
					0: begin
						rd.read_ok = 1'b0;
						rd.raw     = 12'($urandom);
					end
					1: if (sane_hi < 2047)
						rd.raw = 12'(sane_hi + int'($urandom_range(1, 2047 - sane_hi)));
					else
						rd.read_ok = 1'b0;
					default: if (sane_lo > -2048)
						rd.raw = 12'(sane_lo - int'($urandom_range(1, sane_lo + 2048)));
					else
						rd.read_ok = 1'b0;
				endcase
			end else if (pick < 5) begin
				burst = $urandom_range(1, 5);
			end else if (pick < 8) begin
				rd.read_ok = $urandom_range(0, 1);
				rd.raw     = 12'($urandom);
				rd.relay   = $urandom_range(0, 1);
			end
			pending_readings.push_back(rd);
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		reset_shadow();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset configuration (window 0..1600, lower 0, debounce 30)
		add_reading(1'b1, 0, 1'b0);       // first sample loads EMA, lower alert at 0
		add_reading(1'b1, 1600, 1'b1);    // top edge of window
		add_reading(1'b1, 1601, 1'b1);    // just above window
		add_reading(1'b1, -1, 1'b0);      // just below window
		add_reading(1'b0, 800, 1'b1);     // third failure: fault + retry
		add_reading(1'b0, -2048, 1'b0);   // sentinel shown
		add_reading(1'b0, 2047, 1'b1);
		add_reading(1'b1, -880, 1'b0);
		add_reading(1'b1, 2000, 1'b1);    // above window, fault holds
		add_reading(1'b1, 800, 1'b1);     // recover
		add_reading(1'b0, 800, 1'b0);
		add_reading(1'b0, 800, 1'b0);     // two failures, no fault
		add_reading(1'b1, 16, 1'b0);
		add_reading(1'b0, 0, 1'b1);
		add_reading(1'b0, 0, 1'b1);
		add_reading(1'b0, 0, 1'b1);       // fault again
		add_reading(1'b1, 400, 1'b1);     // recover inside debounce: bit stays low
		add_reading(1'b1, 0, 1'b0);
		add_reading(1'b1, 0, 1'b0);       // EMA still above the lower limit, no alert
		wait_idle();

		// full alpha, widest window, one-minute cap, no debounce
		apply_settings(256, -880, 2000, 30, 60, 1, 1, 0);
		queue_walk(350);
		wait_idle();

		// alpha zero freezes the EMA at its current value; max debounce
		apply_settings(0, 0, 1600, 25, 50, 0, 0, 65535);
		queue_walk(200);
		wait_idle();

		// alpha above one, extreme limits, cap out of reach
		apply_settings(511, -880, 2000, 0, 255, 1, 65535, 1);
		queue_walk(150);
		wait_idle();

		// empty sane window: every read fails, fail count saturates
		apply_settings(77, 2000, -880, 20, 40, 1, 2, 5);
		queue_walk(270);
		wait_idle();

		for (int p = 0; p < 3; p++) begin
			int lower;
			lower = $urandom_range(5, 45);
			apply_settings($urandom_range(0, 256), -int'($urandom_range(0, 880)),
				$urandom_range(1400, 2000), lower, lower + int'($urandom_range(3, 30)),
				$urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 40));
			queue_walk(200);
			wait_idle();
		end

		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("water_heater_thermostat_supervisor: match");
		else
			$display("water_heater_thermostat_supervisor: mismatch");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/whts_pkg.sv
src/water_heater_thermostat_supervisor.sv
tb/tb_top.sv
